// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

	localparam int TIME_WIDTH_DEF = 32;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_LEVEL      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DROP_GAP        = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL_US = 2'd2;

	localparam logic        IDLE_LEVEL_RST      = 1'b1;
	localparam logic [15:0] DROP_GAP_RST        = 16'd300;
	localparam logic [23:0] MIN_INTERVAL_US_RST = 24'd180000;

	// Item commands.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic        beam_level;
		logic [31:0] time_ms;
		logic [31:0] time_us;
	} deq_sample_t;

	typedef struct packed {
		logic        drop_accepted;
		logic        edge_seen;
		logic [31:0] drop_total;
		logic [31:0] edge_total;
		logic [31:0] avg_interval_us;
		logic        avg_valid;
	} deq_result_t;

endpackage

// ===== rtl/drip_edge_qualifier_ema_top.sv =====
`timescale 1ns / 1ps

// Drip edge qualifier: counts idle-to-active beam edges, accepts an edge as a drop when at
// least the configured drop gap in milliseconds has passed since the last drop, and keeps a
// smoothed drop interval (avg = (3*avg + interval)/4, seeded by the first qualifying
// interval). A clear item zeroes all statistics but keeps the configuration. Every item
// yields exactly one result item. An accepted item is held in the input register, then in
// the result register; an item in either holds while the result is stalled. One item is
// accepted every cycle while the output is not stalled; the combinational state update
// between the two registers does not limit that rate. Configuration is always ready and
// should be written only while no item is in flight.
module drip_edge_qualifier_ema_top
	import deq_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  deq_sample_t            sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output deq_result_t            result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int InW  = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
	localparam int CmpW = (TIME_WIDTH > 24) ? TIME_WIDTH : 24;

	logic        idle_level_q;
	logic [15:0] min_gap_q;
	logic [23:0] min_interval_q;

	logic                  valid_s1;
	deq_sample_t           sample_s1;

	logic                  prev_active_q;
	logic [TIME_WIDTH-1:0] last_ms_q;
	logic [TIME_WIDTH-1:0] last_us_q;
	logic                  prior_q;
	logic [31:0]           drop_count_q;
	logic [31:0]           edge_count_q;
	logic [TIME_WIDTH-1:0] avg_q;
	logic                  avg_seeded_q;

	logic                  advance;
	logic                  fire_s1;
	logic                  is_clear;
	logic [TIME_WIDTH-1:0] now_ms;
	logic [TIME_WIDTH-1:0] now_us;
	logic [TIME_WIDTH-1:0] gap_ms;
	logic [TIME_WIDTH-1:0] interval;
	logic                  active;
	logic                  edge_hit;
	logic                  drop_hit;
	logic                  take_interval;
	logic [TIME_WIDTH-3:0] qa;
	logic [TIME_WIDTH-3:0] qb;
	logic [3:0]            rsum;
	logic [TIME_WIDTH+1:0] smooth_sum;
	logic [TIME_WIDTH-1:0] avg_next;
	logic                  seeded_next;
	logic [31:0]           drop_next;
	logic [31:0]           edge_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_level_q   <= IDLE_LEVEL_RST;
			min_gap_q      <= DROP_GAP_RST;
			min_interval_q <= MIN_INTERVAL_US_RST;
		end else if (cfg_valid && cfg_ready) begin
			priority if (cfg_index == CFG_IDLE_LEVEL) begin
				idle_level_q <= cfg_data[0];
			end else if (cfg_index == CFG_DROP_GAP) begin
				min_gap_q <= cfg_data[15:0];
			end else if (cfg_index == CFG_MIN_INTERVAL_US) begin
				min_interval_q <= cfg_data;
			end else begin
				// Writes beyond the register list are dropped.
			end
		end
	end

	// The input register advances whenever the result register is free or being emptied.
	assign advance      = !result_valid || !result_stall;
	assign fire_s1      = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	always_comb begin
		is_clear = (sample_s1.cmd == CMD_CLEAR);
		now_ms   = TIME_WIDTH'(sample_s1.time_ms[InW-1:0]);
		now_us   = TIME_WIDTH'(sample_s1.time_us[InW-1:0]);
		gap_ms   = now_ms - last_ms_q;
		interval = now_us - last_us_q;
		active   = (sample_s1.beam_level != idle_level_q);
		edge_hit = !is_clear && active && !prev_active_q;
		drop_hit = edge_hit && (gap_ms >= TIME_WIDTH'(min_gap_q));
		take_interval = drop_hit && prior_q &&
			(CmpW'(interval) > CmpW'(min_interval_q));

		// floor((3*avg + interval)/4) split on quotient and remainder by four, no overflow.
		qa   = avg_q[TIME_WIDTH-1:2];
		qb   = interval[TIME_WIDTH-1:2];
		rsum = 4'(avg_q[1:0]) + 4'({avg_q[1:0], 1'b0}) + 4'(interval[1:0]);
		smooth_sum = (TIME_WIDTH+2)'(qa) + (TIME_WIDTH+2)'({qa, 1'b0})
			+ (TIME_WIDTH+2)'(qb) + (TIME_WIDTH+2)'(rsum[3:2]);

		avg_next    = avg_q;
		seeded_next = avg_seeded_q;
		if (is_clear) begin
			avg_next    = '0;
			seeded_next = 1'b0;
		end else if (take_interval) begin
			avg_next    = avg_seeded_q ? TIME_WIDTH'(smooth_sum) : interval;
			seeded_next = 1'b1;
		end

		if (is_clear) begin
			drop_next = '0;
			edge_next = '0;
		end else begin
			drop_next = drop_count_q + 32'(drop_hit);
			edge_next = edge_count_q + 32'(edge_hit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_active_q <= 1'b0;
			last_ms_q     <= '0;
			last_us_q     <= '0;
			prior_q       <= 1'b0;
			drop_count_q  <= '0;
			edge_count_q  <= '0;
			avg_q         <= '0;
			avg_seeded_q  <= 1'b0;
		end else if (fire_s1) begin
			drop_count_q <= drop_next;
			edge_count_q <= edge_next;
			avg_q        <= avg_next;
			avg_seeded_q <= seeded_next;
			if (is_clear) begin
				prev_active_q <= 1'b0;
				last_ms_q     <= '0;
				last_us_q     <= '0;
				prior_q       <= 1'b0;
			end else begin
				prev_active_q <= active;
				if (drop_hit) begin
					last_ms_q <= now_ms;
					last_us_q <= now_us;
					prior_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result.drop_accepted   <= drop_hit;
			result.edge_seen       <= edge_hit;
			result.drop_total      <= drop_next;
			result.edge_total      <= edge_next;
			result.avg_interval_us <= 32'(avg_next);
			result.avg_valid       <= seeded_next;
		end
	end

	a_drop_needs_edge: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.drop_accepted || result.edge_seen))
		else $error("accepted drop reported without an edge");

	a_seed_drops_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(avg_seeded_q) |-> $past(fire_s1 && sample_s1.cmd == CMD_CLEAR))
		else $error("average lost its seed without a clear item");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> ($stable(edge_count_q) && $stable(drop_count_q) && $stable(avg_q)))
		else $error("statistics changed with no item processed");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import deq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	// Index 3 has no register behind it; a write there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	deq_sample_t            sample = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	deq_result_t            result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	drip_edge_qualifier_ema_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies as the block should hold them.
	logic        set_idle_level = IDLE_LEVEL_RST;
	logic [15:0] set_gap_ms     = DROP_GAP_RST;
	logic [23:0] set_min_iv_us  = MIN_INTERVAL_US_RST;

	// Drop statistics as the block should hold them.
	logic        beam_was_active = 1'b0;
	logic [31:0] last_drop_ms    = '0;
	logic [31:0] last_drop_us    = '0;
	logic        have_prior_drop = 1'b0;
	logic [31:0] drop_cnt        = '0;
	logic [31:0] edge_cnt        = '0;
	logic [31:0] interval_avg    = '0;
	logic        avg_ready       = 1'b0;

	deq_sample_t pending_samples[$];
	deq_result_t expected_results[$];

	int send_idle_pct = 21;
	int recv_stall_pct = 85;
	int n_pushed = 0;
	int n_checked = 0;
	int errors = 0;
	int n_clears = 0;
	int n_edges = 0;
	int n_drops = 0;
	int n_settings = 0;
	int cycles = 0;

	deq_sample_t drv_next;
	logic        drv_next_valid;
	deq_result_t want;

	function automatic deq_result_t qualify_drip(deq_sample_t s);
		deq_result_t r;
		logic        active;
		logic [31:0] interval;
		logic [33:0] blend;
		r = '0;
		if (s.cmd == CMD_CLEAR) begin
			beam_was_active = 1'b0;
			last_drop_ms = '0;
			last_drop_us = '0;
			have_prior_drop = 1'b0;
			drop_cnt = '0;
			edge_cnt = '0;
			interval_avg = '0;
			avg_ready = 1'b0;
		end else begin
			active = (s.beam_level != set_idle_level);
			if (active && !beam_was_active) begin
				r.edge_seen = 1'b1;
				edge_cnt = edge_cnt + 1;
				if (32'(s.time_ms - last_drop_ms) >= {16'b0, set_gap_ms}) begin
					r.drop_accepted = 1'b1;
					if (have_prior_drop) begin
						interval = s.time_us - last_drop_us;
						if (interval > {8'b0, set_min_iv_us}) begin
							if (!avg_ready) begin
								interval_avg = interval;
								avg_ready = 1'b1;
							end else begin
								// Wide enough that 3*avg + interval cannot overflow.
								blend = 34'(interval_avg) * 3 + 34'(interval);
								interval_avg = blend[33:2];
							end
						end
					end
					last_drop_us = s.time_us;
					last_drop_ms = s.time_ms;
					have_prior_drop = 1'b1;
					drop_cnt = drop_cnt + 1;
				end
			end
			beam_was_active = active;
		end
		r.drop_total = drop_cnt;
		r.edge_total = edge_cnt;
		r.avg_interval_us = interval_avg;
		r.avg_valid = avg_ready;
		return r;
	endfunction

	task automatic push_item(input logic cmd, input logic level, input logic [31:0] ms,
			input logic [31:0] us);
		deq_sample_t s;
		s.cmd = cmd;
		s.beam_level = level;
		s.time_ms = ms;
		s.time_us = us;
		pending_samples.push_back(s);
		n_pushed++;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Sender side: one item at a time, held while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
		end else begin
			if (sample_valid && !sample_stall)
				expected_results.push_back(qualify_drip(sample));
			drv_next = sample;
			drv_next_valid = sample_valid;
			if (!sample_valid || !sample_stall) begin
				drv_next_valid = 1'b0;
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_next = pending_samples.pop_front();
					drv_next_valid = 1'b1;
				end
			end
			sample_valid <= drv_next_valid;
			sample <= drv_next;
		end
	end

	// Receiver side: checks each result item against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result item with none expected, got %h", $time, result);
					errors++;
				end else begin
					want = expected_results.pop_front();
					cmp_field("drop_accepted", 32'(want.drop_accepted),
						32'(result.drop_accepted));
					cmp_field("edge_seen", 32'(want.edge_seen), 32'(result.edge_seen));
					cmp_field("drop_total", want.drop_total, result.drop_total);
					cmp_field("edge_total", want.edge_total, result.edge_total);
					cmp_field("avg_interval_us", want.avg_interval_us, result.avg_interval_us);
					cmp_field("avg_valid", 32'(want.avg_valid), 32'(result.avg_valid));
					n_edges += int'(want.edge_seen);
					n_drops += int'(want.drop_accepted);
					n_checked++;
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d items checked", cycles, n_checked,
				n_pushed);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Waits until every item has come back, then lets the pipeline settle.
	task automatic drain();
		while (n_checked != n_pushed)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the three registers back to back, plus index 3 if stray; spare bits are junk.
	task automatic apply_settings(input logic idle, input logic [15:0] gap,
			input logic [23:0] min_iv, input logic stray);
		logic [CFG_INDEX_W-1:0] idx[4];
		logic [CFG_DATA_W-1:0]  val[4];
		int                     n;
		idx[0] = CFG_IDLE_LEVEL;
		val[0] = CFG_DATA_W'($urandom);
		val[0][0] = idle;
		idx[1] = CFG_DROP_GAP;
		val[1] = CFG_DATA_W'($urandom);
		val[1][15:0] = gap;
		idx[2] = CFG_MIN_INTERVAL_US;
		val[2] = min_iv;
		idx[3] = CFG_UNUSED;
		val[3] = CFG_DATA_W'($urandom);
		n = stray ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				CFG_IDLE_LEVEL: set_idle_level = val[i][0];
				CFG_DROP_GAP: set_gap_ms = val[i][15:0];
				CFG_MIN_INTERVAL_US: set_min_iv_us = val[i][23:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Mostly a plausible drip trace with bounces around the gap, plus noise and clears.
	task automatic drip_stream(input int count);
		logic [31:0] now_ms;
		logic [31:0] now_us;
		logic [31:0] dt;
		logic        lvl;
		int          pick;
		now_ms = $urandom;
		now_us = $urandom;
		lvl = 1'($urandom_range(1));
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				push_item(CMD_CLEAR, 1'($urandom_range(1)), $urandom, $urandom);
			end else if (pick < 13) begin
				push_item(CMD_SAMPLE, 1'($urandom_range(1)), $urandom, $urandom);
			end else begin
				if (pick < 15) begin
					now_ms = $urandom;
					now_us = $urandom;
				end
				if ($urandom_range(1))
					dt = $urandom_range(set_gap_ms);
				else
					dt = $urandom_range(2 * set_gap_ms + 1, set_gap_ms);
				now_ms = now_ms + dt;
				if ($urandom_range(1))
					now_us = now_us + dt * 1000 + $urandom_range(999);
				else
					now_us = now_us + $urandom_range(2 * set_min_iv_us + 1);
				if ($urandom_range(9) < 7)
					lvl = !lvl;
				push_item(CMD_SAMPLE, lvl, now_ms, now_us);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed trace under the reset settings (idle high, 300 ms, 180000 us).
		push_item(CMD_SAMPLE, 1'b1, 32'd0, 32'd0);
		push_item(CMD_SAMPLE, 1'b0, 32'd0, 32'd0);          // edge too close to time zero
		push_item(CMD_SAMPLE, 1'b1, 32'd10, 32'd10000);
		push_item(CMD_SAMPLE, 1'b0, 32'd300, 32'd0);        // first drop, stamped at us zero
		push_item(CMD_SAMPLE, 1'b0, 32'd310, 32'd10000);    // held active, no edge
		push_item(CMD_SAMPLE, 1'b1, 32'd400, 32'd100000);
		push_item(CMD_SAMPLE, 1'b0, 32'd500, 32'd200000);   // bounce inside the gap
		push_item(CMD_SAMPLE, 1'b1, 32'd550, 32'd250000);
		push_item(CMD_SAMPLE, 1'b0, 32'd600, 32'd180000);   // interval equal to minimum
		push_item(CMD_SAMPLE, 1'b1, 32'd700, 32'd200000);
		push_item(CMD_SAMPLE, 1'b0, 32'd900, 32'd360001);   // seeds the average
		push_item(CMD_SAMPLE, 1'b1, 32'd1000, 32'd400000);
		push_item(CMD_SAMPLE, 1'b0, 32'd1300, 32'd1000000); // smoothing step
		push_item(CMD_SAMPLE, 1'b1, 32'hFFFF_FFF0, 32'h8000_0000);
		push_item(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(CMD_SAMPLE, 1'b1, 32'h0000_0100, 32'h0000_0100);
		push_item(CMD_SAMPLE, 1'b0, 32'd300, 32'h0000_1000);  // both timestamps wrapped
		push_item(CMD_CLEAR, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(CMD_SAMPLE, 1'b0, 32'd5, 32'd5000);       // gap measured from zero after clear
		push_item(CMD_SAMPLE, 1'b1, 32'd6, 32'd6000);
		push_item(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF, 32'd0);
		push_item(CMD_CLEAR, 1'b0, 32'd0, 32'd0);
		drain();

		apply_settings(1'b0, 16'd0, 24'd0, 1'b1);
		drip_stream(300);
		drain();

		send_idle_pct = 85;
		recv_stall_pct = 21;
		apply_settings(1'b1, 16'hFFFF, 24'hFF_FFFF, 1'b0);
		drip_stream(300);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		apply_settings(1'($urandom_range(1)), 16'($urandom_range(2000, 1)),
			24'($urandom_range(2000000)), 1'b1);
		drip_stream(150);
		drain();
		apply_settings(IDLE_LEVEL_RST, DROP_GAP_RST, MIN_INTERVAL_US_RST, 1'b0);
		drip_stream(150);
		drain();

		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected result items never arrived", $time,
				expected_results.size());
			errors++;
		end
		$display("checked %0d items under %0d register settings plus reset values", n_checked,
			n_settings);
		$display("stream held %0d raw edges and %0d accepted drops; %0d errors", n_edges,
			n_drops, errors);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== drip_edge_qualifier_ema_top.f =====
rtl/deq_pkg.sv
rtl/drip_edge_qualifier_ema_top.sv
sim/tb_top.sv
